// ===== src/ddtc_pkg.sv =====
// Package for the differential-drive turn control block.
// Holds turning-mode codes, register indexes and the CORDIC angle table.
// Depends on nothing.
package ddtc_pkg;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_SOFT = 2'd1,
    MODE_HARD = 2'd2
  } turn_mode_t;

  localparam logic [1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [1:0] REG_HARD_THR  = 2'd1;
  localparam logic [1:0] REG_SOFT_THR  = 2'd2;
  localparam logic [1:0] REG_NONE_THR  = 2'd3;

  localparam int AtanSteps = 24;

  // Arctangent of 2^-i in units of pi/2^23.
  function automatic logic [21:0] atan_lookup(input logic [4:0] idx);
    logic [21:0] r;
    unique case (idx)
      5'd0:  r = 22'd2097152;
      5'd1:  r = 22'd1238021;
      5'd2:  r = 22'd654136;
      5'd3:  r = 22'd332050;
      5'd4:  r = 22'd166669;
      5'd5:  r = 22'd83415;
      5'd6:  r = 22'd41718;
      5'd7:  r = 22'd20860;
      5'd8:  r = 22'd10430;
      5'd9:  r = 22'd5215;
      5'd10: r = 22'd2608;
      5'd11: r = 22'd1304;
      5'd12: r = 22'd652;
      5'd13: r = 22'd326;
      5'd14: r = 22'd163;
      5'd15: r = 22'd81;
      5'd16: r = 22'd41;
      5'd17: r = 22'd20;
      5'd18: r = 22'd10;
      5'd19: r = 22'd5;
      5'd20: r = 22'd3;
      5'd21: r = 22'd1;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/differential_drive_turn_control.sv =====
// Top level of the differential-drive turn control block.
// Holds the CORDIC sequencer, mode update, divider and APB registers.
// Depends on ddtc_pkg.
//
//  Channel | Direction | Handshake         | Payload
//  in_     | slave     | tvalid / tready   | tdata: heading_x, heading_y
//  out_    | master    | tvalid / tready   | tdata: left_speed, right_speed, turn_mode
//  cfg_    | APB slave | psel/penable/prdy | four 15-bit registers
//
// The vectoring CORDIC runs one step a cycle for min(CORDIC_STEPS, 24) steps,
// followed by a state for angle and length and one for the mode update.
// Soft turn then finds its quotient with a restoring divider, one bit a cycle
// for 31 bits, and then forms the speeds before the result is offered. No turn
// and hard turn skip the divider.
// Reset is synchronous and active low. A new item is taken once the result
// register is free; a stalled result holds the block in its output state.
module differential_drive_turn_control #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] heading_x, [31:16] heading_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] left_speed, [31:16] right_speed, [33:32] turn_mode
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NSteps = (CORDIC_STEPS < ddtc_pkg::AtanSteps) ?
                          CORDIC_STEPS : ddtc_pkg::AtanSteps;
  localparam logic [4:0] LastStep = 5'(NSteps - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROT, ST_LEN, ST_MODE, ST_DIV, ST_OUT
  } state_t;

  state_t state_r;
  logic [14:0] max_speed_r, hard_thr_r, soft_thr_r, none_thr_r;
  ddtc_pkg::turn_mode_t mode_r;
  logic signed [26:0] x_r, y_r;
  logic signed [24:0] z_r;
  logic [4:0] step_r;
  logic zero_r;
  logic signed [16:0] ang_r;
  logic [15:0] mag_r;
  logic [14:0] base_r;
  logic [30:0] dividend_r;
  logic [31:0] rem_r;
  logic [30:0] quot_r;
  logic [4:0] bit_r;
  logic signed [15:0] left_r, right_r;
  logic [1:0] omode_r;

  // Register access.
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[3:2])
      ddtc_pkg::REG_MAX_SPEED: cfg_prdata = {17'd0, max_speed_r};
      ddtc_pkg::REG_HARD_THR:  cfg_prdata = {17'd0, hard_thr_r};
      ddtc_pkg::REG_SOFT_THR:  cfg_prdata = {17'd0, soft_thr_r};
      default:                 cfg_prdata = {17'd0, none_thr_r};
    endcase
  end

  // Shared add/subtract for one CORDIC step.
  logic signed [26:0] dx, dy;
  logic signed [24:0] at;
  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;
  assign at = 25'(ddtc_pkg::atan_lookup(step_r));

  // Final angle rounding and wrap.
  logic signed [24:0] zr;
  logic signed [16:0] ang_w;
  assign zr = z_r + 25'sd128;
  always_comb begin
    ang_w = 17'(zr >>> 8);
    if (ang_w > 17'sd32768) ang_w = ang_w - 17'sd65536;
    else if (ang_w <= -17'sd32768) ang_w = ang_w + 17'sd65536;
  end

  // Length multiply.
  logic signed [44:0] prod;
  logic signed [20:0] len_w;
  assign prod = 45'(x_r) * 45'sd39797 + 45'sd8388608;
  assign len_w = 21'(prod >>> 24);

  // Mode update with hysteresis.
  ddtc_pkg::turn_mode_t m1, m2, m3;
  always_comb begin
    m1 = mode_r;
    if (m1 == ddtc_pkg::MODE_HARD && mag_r <= {1'b0, soft_thr_r}) m1 = ddtc_pkg::MODE_SOFT;
    m2 = m1;
    if (m1 == ddtc_pkg::MODE_SOFT) begin
      if (mag_r > {1'b0, hard_thr_r}) m2 = ddtc_pkg::MODE_HARD;
      else if (mag_r <= {1'b0, none_thr_r}) m2 = ddtc_pkg::MODE_NONE;
    end
    m3 = m2;
    if (m2 == ddtc_pkg::MODE_NONE) begin
      if (mag_r > {1'b0, hard_thr_r}) m3 = ddtc_pkg::MODE_HARD;
      else if (mag_r > {1'b0, none_thr_r}) m3 = ddtc_pkg::MODE_SOFT;
    end
  end

  // Divider step and final speeds.
  logic [31:0] rem_sh;
  logic [31:0] rem_sub;
  assign rem_sh = {rem_r[30:0], dividend_r[30]};
  assign rem_sub = rem_sh - {17'd0, hard_thr_r};

  logic signed [17:0] t_s, inner_s, outer_s;
  logic signed [15:0] inner_q, outer_q;
  assign t_s = (hard_thr_r == 15'd0) ? 18'sd0 : $signed({1'b0, quot_r[16:0]});
  assign inner_s = $signed({3'd0, base_r}) - t_s;
  assign outer_s = $signed({3'd0, base_r}) + t_s;
  assign inner_q = (inner_s < -18'sd32768) ? -16'sd32768 :
                   (inner_s > 18'sd32767) ? 16'sd32767 : 16'(inner_s);
  assign outer_q = (outer_s > 18'sd32767) ? 16'sd32767 :
                   (outer_s < -18'sd32768) ? -16'sd32768 : 16'(outer_s);
  // quot beyond 17 bits saturates inner/outer anyway.
  logic q_big;
  assign q_big = |quot_r[30:17];

  // The cycle that forms the soft-turn speeds offers no result yet.
  logic forming;
  assign forming = (omode_r == ddtc_pkg::MODE_SOFT) && (bit_r == 5'd31);

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT) && !forming;
  assign out_tdata = {6'd0, omode_r, right_r, left_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r <= ddtc_pkg::MODE_NONE;
      max_speed_r <= 15'd2560;
      hard_thr_r <= 15'd16384;
      soft_thr_r <= 15'd12288;
      none_thr_r <= 15'd1820;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          ddtc_pkg::REG_MAX_SPEED: max_speed_r <= cfg_pwdata[14:0];
          ddtc_pkg::REG_HARD_THR:  hard_thr_r <= cfg_pwdata[14:0];
          ddtc_pkg::REG_SOFT_THR:  soft_thr_r <= cfg_pwdata[14:0];
          default:                 none_thr_r <= cfg_pwdata[14:0];
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            // Pre-rotate into the right half-plane.
            zero_r <= (in_tdata == 32'd0);
            step_r <= 5'd0;
            if (in_tdata[15]) begin
              if (!in_tdata[31]) begin
                x_r <= 27'($signed(in_tdata[31:16])) <<< 8;
                y_r <= -(27'($signed(in_tdata[15:0])) <<< 8);
                z_r <= 25'sd4194304;
              end else begin
                x_r <= -(27'($signed(in_tdata[31:16])) <<< 8);
                y_r <= 27'($signed(in_tdata[15:0])) <<< 8;
                z_r <= -25'sd4194304;
              end
            end else begin
              x_r <= 27'($signed(in_tdata[15:0])) <<< 8;
              y_r <= 27'($signed(in_tdata[31:16])) <<< 8;
              z_r <= 25'sd0;
            end
            state_r <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (!y_r[26]) begin
            x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + at;
          end else begin
            x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - at;
          end
          step_r <= step_r + 5'd1;
          if (step_r == LastStep) state_r <= ST_LEN;
        end
        ST_LEN: begin
          // Angle, magnitude, length and capped base speed.
          logic signed [16:0] a;
          logic [15:0] l;
          a = zero_r ? 17'sd0 : ang_w;
          l = (zero_r || len_w < 0) ? 16'd0 :
              (len_w > 21'sd65535) ? 16'hFFFF : 16'(len_w);
          ang_r <= a;
          mag_r <= a[16] ? 16'(-a) : 16'(a);
          base_r <= (l < {1'b0, max_speed_r}) ? l[14:0] : max_speed_r;
          state_r <= ST_MODE;
        end
        ST_MODE: begin
          mode_r <= m3;
          dividend_r <= ({16'd0, base_r} * {15'd0, mag_r}) + 31'(hard_thr_r >> 1);
          rem_r <= 32'd0;
          quot_r <= 31'd0;
          bit_r <= 5'd30;
          state_r <= (m3 == ddtc_pkg::MODE_SOFT) ? ST_DIV : ST_OUT;
          omode_r <= m3;
          if (m3 == ddtc_pkg::MODE_HARD) begin
            left_r <= ang_r > 0 ? -$signed({1'b0, max_speed_r}) : $signed({1'b0, max_speed_r});
            right_r <= ang_r > 0 ? $signed({1'b0, max_speed_r}) : -$signed({1'b0, max_speed_r});
          end else begin
            left_r <= $signed({1'b0, base_r});
            right_r <= $signed({1'b0, base_r});
          end
        end
        ST_DIV: begin
          // One restoring-division bit per cycle.
          dividend_r <= {dividend_r[29:0], 1'b0};
          if (!rem_sub[31] && hard_thr_r != 15'd0) begin
            rem_r <= rem_sub; quot_r <= {quot_r[29:0], 1'b1};
          end else begin
            rem_r <= rem_sh; quot_r <= {quot_r[29:0], 1'b0};
          end
          bit_r <= bit_r - 5'd1;
          if (bit_r == 5'd0) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (forming) begin
            // First cycle after division: form speeds.
            bit_r <= 5'd0;
            if (ang_r > 0) begin
              left_r <= q_big ? -16'sd32768 : inner_q;
              right_r <= q_big ? 16'sd32767 : outer_q;
            end else begin
              left_r <= q_big ? 16'sd32767 : outer_q;
              right_r <= q_big ? -16'sd32768 : inner_q;
            end
          end else if (out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // No result is offered while an input transaction is being taken.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("in and out both active");
  // Hard turn spins the wheels in opposite directions at max speed.
  a_hard: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && omode_r == ddtc_pkg::MODE_HARD) |->
    (left_r == -right_r)) else $error("hard turn speeds not opposite");
  // The offered mode matches the stored turning mode.
  a_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (omode_r == mode_r)) else $error("result mode differs from state");
`endif

endmodule
